### hw/rtl/button_action_mapper_autorepeat_core_macros.svh
// Assertion macros for the button action mapper.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BUTTON_ACTION_MAPPER_AUTOREPEAT_CORE_MACROS_SVH
`define BUTTON_ACTION_MAPPER_AUTOREPEAT_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define BAMA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bama: implication check failed");
// next-cycle implication
`define BAMA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bama: next-cycle check failed");
`else
`define BAMA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BAMA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/bama_pkg.sv
// Shared types and constants for the button action mapper.
// No dependencies; used by the interfaces, the step logic and the top level.
package bama_pkg;

   localparam int MaxButtons = 16;
   localparam int StampWidth = 64;
   localparam int TimeWidth  = 32;
   localparam int CsrWidth   = 32;
   localparam int CsrIdxWidth = 2;

   typedef enum logic [3:0] {
      ACT_NONE     = 4'd0,
      ACT_UP       = 4'd1,
      ACT_DOWN     = 4'd2,
      ACT_LEFT     = 4'd3,
      ACT_RIGHT    = 4'd4,
      ACT_BACK     = 4'd5,
      ACT_PREVIOUS = 4'd6,
      ACT_NEXT     = 4'd7,
      ACT_CONFIRM  = 4'd8
   } action_type;

   typedef enum logic [2:0] {
      DIR_NONE  = 3'd0,
      DIR_UP    = 3'd1,
      DIR_DOWN  = 3'd2,
      DIR_LEFT  = 3'd3,
      DIR_RIGHT = 3'd4
   } dir_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DIRECTION_MAP = 2'd0,
      CSR_COMMAND_MAP   = 2'd1,
      CSR_REPEAT_DELAY  = 2'd2,
      CSR_REPEAT_PERIOD = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic                  synced;
      logic [MaxButtons-1:0] blocked;
      logic [MaxButtons-1:0] prev_active;
      dir_type               cur_dir;
      logic                  in_repeat;
      logic [StampWidth-1:0] last_stamp;
      logic [StampWidth-1:0] repeat_stamp;
   } state_type;

   typedef struct packed {
      logic                  ok;
      logic [MaxButtons-1:0] dir_map;
      logic [MaxButtons-1:0] cmd_map;
      logic [TimeWidth-1:0]  delay;
      logic [TimeWidth-1:0]  period;
   } cfg_type;

endpackage

### hw/rtl/bama_if.sv
// Valid/ready channel interfaces for the sample and action words.
// Depends on bama_pkg for field widths and the action code type.
interface bama_req_if import bama_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  link_up;
   logic [MaxButtons-1:0] buttons_down;
   logic [StampWidth-1:0] now_us;

   modport source (output valid, link_up, buttons_down, now_us, input ready);
   modport sink (input valid, link_up, buttons_down, now_us, output ready);
endinterface

interface bama_rsp_if import bama_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action_code;

   modport source (output valid, action_code, input ready);
   modport sink (input valid, action_code, output ready);
endinterface

### hw/rtl/bama_step.sv
// Per-sample decision logic: resync, edge detect, direction repeat, priority.
// Depends on bama_pkg; purely combinational, state is held by the caller.
module bama_step import bama_pkg::*; #(
   parameter int BUTTON_COUNT = 16
) (
   input  cfg_type               cfg,
   input  state_type             st,
   input  logic                  link_up,
   input  logic [MaxButtons-1:0] buttons_down,
   input  logic [StampWidth-1:0] now_us,
   output state_type             st_next,
   output action_type            action
);

   localparam logic [MaxButtons-1:0] LineMask =
      MaxButtons'((33'd1 << BUTTON_COUNT) - 33'd1);

   always_comb begin
      logic [MaxButtons-1:0] down;
      logic [MaxButtons-1:0] blocked_n;
      logic [MaxButtons-1:0] active;
      logic [MaxButtons-1:0] edges;
      logic [StampWidth-1:0] elapsed;
      logic [TimeWidth-1:0]  thresh;
      logic                  hu, hd, hl, hr, both_pn, due;
      dir_type               dir;
      dir_type               move;

      down      = buttons_down & LineMask;
      blocked_n = st.blocked & down;
      active    = down & ~blocked_n;
      edges     = active & ~st.prev_active;

      hu = active[cfg.dir_map[3:0]];
      hd = active[cfg.dir_map[7:4]];
      hl = active[cfg.dir_map[11:8]];
      hr = active[cfg.dir_map[15:12]];

      // up/down wins over left/right; opposing pairs cancel
      if (hu != hd) begin
         dir = hu ? DIR_UP : DIR_DOWN;
      end else if (hl != hr) begin
         dir = hl ? DIR_LEFT : DIR_RIGHT;
      end else begin
         dir = DIR_NONE;
      end

      elapsed = now_us - st.repeat_stamp;
      thresh  = st.in_repeat ? cfg.period : cfg.delay;
      due     = (elapsed >= {{(StampWidth-TimeWidth){1'b0}}, thresh});
      both_pn = active[cfg.cmd_map[7:4]] && active[cfg.cmd_map[11:8]];

      st_next = st;
      action  = ACT_NONE;
      move    = DIR_NONE;

      if (!cfg.ok || !link_up) begin
         st_next.synced = 1'b0;
      end else if (!st.synced || (now_us < st.last_stamp)) begin
         // resync: hold off anything already pressed
         st_next.synced      = 1'b1;
         st_next.blocked     = down;
         st_next.prev_active = '0;
         st_next.cur_dir     = DIR_NONE;
         st_next.in_repeat   = 1'b0;
         st_next.last_stamp  = now_us;
      end else begin
         st_next.last_stamp  = now_us;
         st_next.blocked     = blocked_n;
         st_next.prev_active = active;

         if (dir != st.cur_dir) begin
            st_next.cur_dir      = dir;
            st_next.repeat_stamp = now_us;
            st_next.in_repeat    = 1'b0;
            move                 = dir;
         end else if ((dir != DIR_NONE) && due) begin
            st_next.repeat_stamp = now_us;
            st_next.in_repeat    = 1'b1;
            move                 = dir;
         end

         if (edges[cfg.cmd_map[3:0]]) begin
            action = ACT_BACK;
         end else if (!both_pn && edges[cfg.cmd_map[7:4]]) begin
            action = ACT_PREVIOUS;
         end else if (!both_pn && edges[cfg.cmd_map[11:8]]) begin
            action = ACT_NEXT;
         end else if (edges[cfg.cmd_map[15:12]]) begin
            action = ACT_CONFIRM;
         end else begin
            action = action_type'({1'b0, move});
         end
      end
   end

endmodule

### hw/rtl/button_action_mapper_autorepeat_core.sv
// Path: a sample word is taken into the input register, passes the decision stage, and
// its action word is offered from the result register (input reg, result reg).
// Throughput: one sample word per cycle while the sink takes action words, set by the
// single decision stage between the input and result registers; state is written back there.
// Stall: an action word held by the sink parks the next sample in the input register.
// Reset (synchronous, active high): pipeline empty, not synced, repeat state cleared.
`include "button_action_mapper_autorepeat_core_macros.svh"
module button_action_mapper_autorepeat_core import bama_pkg::*; #(
   parameter int BUTTON_COUNT = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   bama_req_if.sink               req_ch,
   bama_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [MaxButtons-1:0] dir_map_ff, dir_map_in;
   logic [MaxButtons-1:0] cmd_map_ff, cmd_map_in;
   logic [TimeWidth-1:0]  delay_ff, delay_in;
   logic [TimeWidth-1:0]  period_ff, period_in;
   logic                  cfg_ok_ff, cfg_ok_in;

   always_comb begin
      dir_map_in = dir_map_ff;
      cmd_map_in = cmd_map_ff;
      delay_in   = delay_ff;
      period_in  = period_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_DIRECTION_MAP: dir_map_in = csr_wdata[MaxButtons-1:0];
            CSR_COMMAND_MAP:   cmd_map_in = csr_wdata[MaxButtons-1:0];
            CSR_REPEAT_DELAY:  delay_in   = csr_wdata[TimeWidth-1:0];
            CSR_REPEAT_PERIOD: period_in  = csr_wdata[TimeWidth-1:0];
            default: ;
         endcase
      end
   end

   // Validity of the mapping: all eight indices distinct and in range, both
   // times nonzero. Registered; the user must change config only while idle (unenforced),
   // so the flag has settled before the next sample reaches the decision stage.
   always_comb begin
      logic [3:0] idx [8];
      for (int i = 0; i < 4; i++) begin
         idx[i]     = dir_map_ff[4*i +: 4];
         idx[i + 4] = cmd_map_ff[4*i +: 4];
      end
      cfg_ok_in = (delay_ff != '0) && (period_ff != '0);
      for (int i = 0; i < 8; i++) begin
         if ({1'b0, idx[i]} >= 5'(BUTTON_COUNT)) begin
            cfg_ok_in = 1'b0;
         end
         for (int j = i + 1; j < 8; j++) begin
            if (idx[i] == idx[j]) begin
               cfg_ok_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_map_ff <= 16'h3210;
         cmd_map_ff <= 16'h7654;
         delay_ff   <= 32'd500000;
         period_ff  <= 32'd100000;
         cfg_ok_ff  <= 1'b0;
      end else begin
         dir_map_ff <= dir_map_in;
         cmd_map_ff <= cmd_map_in;
         delay_ff   <= delay_in;
         period_ff  <= period_in;
         cfg_ok_ff  <= cfg_ok_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake: input register feeds the decision stage, result register
   // holds the action word. The input register advances whenever the
   // result register is empty or being drained; a waiting result keeps
   // one sample parked in the input register and holds off the next.
   // ---------------------------------------------------------------
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_link_ff;
   logic [MaxButtons-1:0] s1_down_ff;
   logic [StampWidth-1:0] s1_now_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   action_type            rsp_action_ff;
   logic                  req_fire;
   logic                  step_fire;

   assign step_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || step_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (step_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = step_fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.action_code = rsp_action_ff;

   // ---------------------------------------------------------------
   // Decision stage
   // ---------------------------------------------------------------
   cfg_type    cfg;
   state_type  st_ff, st_in, st_step;
   action_type step_action;

   assign cfg = {cfg_ok_ff, dir_map_ff, cmd_map_ff, delay_ff, period_ff};

   bama_step #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_step (
      .cfg          (cfg),
      .st           (st_ff),
      .link_up      (s1_link_ff),
      .buttons_down (s1_down_ff),
      .now_us       (s1_now_ff),
      .st_next      (st_step),
      .action       (step_action)
   );

   // any config write drops the connection; it wins over a same-cycle step
   always_comb begin
      st_in = step_fire ? st_step : st_ff;
      if (csr_we) begin
         st_in.synced = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_link_ff <= req_ch.link_up;
         s1_down_ff <= req_ch.buttons_down;
         s1_now_ff  <= req_ch.now_us;
      end
      if (step_fire) begin
         rsp_action_ff <= step_action;
      end
   end

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `BAMA_ASSERT_NXT(a_csr_drops_sync, clock, reset, csr_we, !st_ff.synced)
   `BAMA_ASSERT_NXT(a_link_down_unsyncs, clock, reset, step_fire && !s1_link_ff, !st_ff.synced)
   `BAMA_ASSERT_NXT(a_bad_cfg_silent, clock, reset, step_fire && !cfg.ok, rsp_action_ff == ACT_NONE)
   `BAMA_ASSERT_IMP(a_stall_only_when_full, clock, reset, !req_ch.ready, s1_valid_ff && !step_fire)
   `BAMA_ASSERT_NXT(a_step_loads_result, clock, reset, step_fire, rsp_valid_ff)

endmodule

### tb/sv/tb.sv
// Self-checking bench for button_action_mapper_autorepeat_core: random sample words
// against an in-bench action predictor, with register phases between bursts.
// Depends on bama_pkg and the bama_req_if / bama_rsp_if interfaces from the RTL.
module tb;
   import bama_pkg::*;

   // one sample word as queued for the driver
   typedef struct {
      logic                  link;
      logic [MaxButtons-1:0] buttons;
      logic [StampWidth-1:0] stamp;
   } sample_word_type;

   // clock and reset: 12 unit period, reset released at a falling edge
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // channel drive state; every block input is known from time zero
   logic                  req_valid   = 1'b0;
   logic                  req_link    = 1'b0;
   logic [MaxButtons-1:0] req_buttons = '0;
   logic [StampWidth-1:0] req_stamp   = '0;
   logic                  rsp_ready   = 1'b0;
   logic                  csr_we      = 1'b0;
   csr_idx_type           csr_index   = CSR_DIRECTION_MAP;
   logic [CsrWidth-1:0]   csr_wdata   = '0;

   bama_req_if req_if();
   bama_rsp_if rsp_if();

   assign req_if.valid        = req_valid;
   assign req_if.link_up      = req_link;
   assign req_if.buttons_down = req_buttons;
   assign req_if.now_us       = req_stamp;
   assign rsp_if.ready        = rsp_ready;

   button_action_mapper_autorepeat_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // stimulus words waiting to go out, and actions waiting to come back
   sample_word_type sample_q[$];
   action_type      action_q[$];
   int              mismatches = 0;

   // idle bursts allowed on both channels while set
   bit idle_ok = 1'b1;
   int req_gap = 0;
   int rsp_gap = 0;
   logic req_fire = 1'b0;

   // ---------------------------------------------------------------------
   // Action predictor: registers and tracking state, updated at the
   // rising edge where a sample word or a register write is taken.
   // ---------------------------------------------------------------------
   logic [15:0]           map_dir_m;
   logic [15:0]           map_cmd_m;
   logic [31:0]           delay_m;
   logic [31:0]           period_m;
   logic                  synced_m;
   logic [MaxButtons-1:0] blocked_m;
   logic [MaxButtons-1:0] prev_active_m;
   dir_type               dir_m;
   logic                  repeating_m;
   logic [StampWidth-1:0] last_stamp_m;
   logic [StampWidth-1:0] rep_stamp_m;

   // button line of slot 0..7: up, down, left, right, back, previous, next, confirm
   function automatic logic [3:0] line_of(input int slot);
      return (slot < 4) ? map_dir_m[slot*4 +: 4] : map_cmd_m[(slot-4)*4 +: 4];
   endfunction

   function automatic logic held(input logic [MaxButtons-1:0] vec, input action_type act);
      return vec[line_of(int'(act) - 1)];
   endfunction

   // any shared line or a zero timer leaves the block dead
   function automatic logic map_ok();
      logic [15:0] used;
      logic [3:0]  line;
      used = '0;
      if (delay_m == 0 || period_m == 0)
         return 1'b0;
      for (int s = 0; s < 8; s++) begin
         line = line_of(s);
         if (used[line])
            return 1'b0;
         used[line] = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic action_type next_action(input logic link,
                                              input logic [MaxButtons-1:0] down,
                                              input logic [StampWidth-1:0] now);
      logic [MaxButtons-1:0] active;
      logic [MaxButtons-1:0] rising;
      logic                  hu, hd, hl, hr, both_pn;
      dir_type               dir;
      dir_type               move;
      if (!map_ok() || !link) begin
         synced_m = 1'b0;
         return ACT_NONE;
      end
      // first linked word after a drop, or time ran backwards: resync
      if (!synced_m || now < last_stamp_m) begin
         synced_m      = 1'b1;
         blocked_m     = down;
         prev_active_m = '0;
         dir_m         = DIR_NONE;
         repeating_m   = 1'b0;
         last_stamp_m  = now;
         return ACT_NONE;
      end
      last_stamp_m  = now;
      blocked_m     = blocked_m & down;
      active        = down & ~blocked_m;
      rising        = active & ~prev_active_m;
      prev_active_m = active;

      hu = held(active, ACT_UP);
      hd = held(active, ACT_DOWN);
      hl = held(active, ACT_LEFT);
      hr = held(active, ACT_RIGHT);
      // vertical axis wins; opposite keys on an axis cancel
      dir = DIR_NONE;
      if (hu != hd)
         dir = hu ? DIR_UP : DIR_DOWN;
      else if (hl != hr)
         dir = hl ? DIR_LEFT : DIR_RIGHT;

      move = DIR_NONE;
      if (dir != dir_m) begin
         dir_m       = dir;
         rep_stamp_m = now;
         repeating_m = 1'b0;
         move        = dir;
      end else if (dir != DIR_NONE &&
                   now - rep_stamp_m >= 64'(repeating_m ? period_m : delay_m)) begin
         move        = dir;
         rep_stamp_m = now;
         repeating_m = 1'b1;
      end

      both_pn = held(active, ACT_PREVIOUS) && held(active, ACT_NEXT);
      if (held(rising, ACT_BACK))
         return ACT_BACK;
      if (!both_pn && held(rising, ACT_PREVIOUS))
         return ACT_PREVIOUS;
      if (!both_pn && held(rising, ACT_NEXT))
         return ACT_NEXT;
      if (held(rising, ACT_CONFIRM))
         return ACT_CONFIRM;
      return action_type'(4'(move));
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: samples at the rising edge, checks returned action words
   // in order and predicts each accepted sample word.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      action_type want;
      if (reset) begin
         map_dir_m     = 16'h3210;
         map_cmd_m     = 16'h7654;
         delay_m       = 32'd500000;
         period_m      = 32'd100000;
         synced_m      = 1'b0;
         blocked_m     = '0;
         prev_active_m = '0;
         dir_m         = DIR_NONE;
         repeating_m   = 1'b0;
         last_stamp_m  = '0;
         rep_stamp_m   = '0;
         req_fire     <= 1'b0;
      end else begin
         req_fire <= req_valid && req_if.ready;
         // any register write drops the connection
         if (csr_we) begin
            case (csr_index)
               CSR_DIRECTION_MAP: map_dir_m = csr_wdata[15:0];
               CSR_COMMAND_MAP:   map_cmd_m = csr_wdata[15:0];
               CSR_REPEAT_DELAY:  delay_m   = csr_wdata[31:0];
               CSR_REPEAT_PERIOD: period_m  = csr_wdata[31:0];
               default: ;
            endcase
            synced_m = 1'b0;
         end
         if (rsp_if.valid && rsp_ready) begin
            if (action_q.size() == 0) begin
               mismatches++;
               $display("%0t: action word with nothing pending, expected none got %0d",
                        $time, rsp_if.action_code);
            end else begin
               want = action_q.pop_front();
               if (rsp_if.action_code !== want) begin
                  mismatches++;
                  $display("%0t: action mismatch, expected %0d got %0d",
                           $time, want, rsp_if.action_code);
               end
            end
         end
         if (req_valid && req_if.ready)
            action_q.push_back(next_action(req_link, req_buttons, req_stamp));
      end
   end

   // ---------------------------------------------------------------------
   // Driver: moves on at the falling edge once the current word is taken,
   // with optional idle bursts between words.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      sample_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_fire) begin
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (idle_ok && $urandom_range(0, 3) == 0) begin
            req_gap = $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            w = sample_q.pop_front();
            req_valid   <= 1'b1;
            req_link    <= w.link;
            req_buttons <= w.buttons;
            req_stamp   <= w.stamp;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure, same burst shape
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap = 0;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 3) == 0) begin
         rsp_gap = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic add_sample(input logic link, input logic [15:0] buttons,
                             input logic [63:0] stamp);
      sample_word_type w;
      w.link    = link;
      w.buttons = buttons;
      w.stamp   = stamp;
      sample_q.push_back(w);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // block is idle once nothing is queued, in flight or owed
   task automatic drain();
      while (sample_q.size() != 0 || req_valid || action_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [3:0]  perm [16];
      logic [3:0]  mapped [8];
      logic [3:0]  t;
      logic [15:0] dmap, cmap, held_now;
      logic [31:0] dly, per;
      logic [63:0] stamp;
      int          j, r, count;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words under the reset map: up=0 down=1 left=2 right=3,
      // back=4 previous=5 next=6 confirm=7
      add_sample(1'b0, 16'hFFFF, 64'd0);             // link down
      add_sample(1'b1, 16'h0001, 64'd10);            // resync with up held
      add_sample(1'b1, 16'h0001, 64'd20);            // up still blocked
      add_sample(1'b1, 16'h0000, 64'd30);            // release clears the block
      add_sample(1'b1, 16'h0001, 64'd40);            // fresh up
      add_sample(1'b1, 16'h0001, 64'd500040);        // first repeat after delay
      add_sample(1'b1, 16'h0001, 64'd600040);        // periodic repeat
      add_sample(1'b1, 16'h0003, 64'd600050);        // up and down cancel
      add_sample(1'b1, 16'h0004, 64'd600060);        // left
      add_sample(1'b1, 16'h000C, 64'd600070);        // left and right cancel
      add_sample(1'b1, 16'h0008, 64'd600080);        // right
      add_sample(1'b1, 16'h0010, 64'd600090);        // back
      add_sample(1'b1, 16'h0030, 64'd600100);        // previous edge
      add_sample(1'b1, 16'h0070, 64'd600110);        // previous+next held: muted
      add_sample(1'b1, 16'h0000, 64'd600120);
      add_sample(1'b1, 16'h0080, 64'd600130);        // confirm
      add_sample(1'b1, 16'hFFFF, 64'd600140);        // everything, back wins
      add_sample(1'b1, 16'hFFFF, 64'd5);             // time backwards: resync
      add_sample(1'b1, 16'h0000, 64'hFFFF_FFFF_FFFF_FFF0);
      add_sample(1'b1, 16'h0002, 64'hFFFF_FFFF_FFFF_FFFE); // down
      add_sample(1'b1, 16'h0002, 64'hFFFF_FFFF_FFFF_FFFF); // no repeat yet
      add_sample(1'b0, 16'h0002, 64'hFFFF_FFFF_FFFF_FFFF); // drop link
      stamp = 64'd1000;

      for (int phase = 0; phase < 10; phase++) begin
         drain();

         // random permutation gives eight distinct lines
         for (int i = 0; i < 16; i++)
            perm[i] = 4'(i);
         for (int i = 15; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
         end
         for (int k = 0; k < 8; k++)
            mapped[k] = perm[k];
         dmap = {perm[3], perm[2], perm[1], perm[0]};
         cmap = {perm[7], perm[6], perm[5], perm[4]};
         dly  = $urandom_range(1, 40);
         per  = $urandom_range(1, 20);
         case (phase)
            0: begin
               dly = 32'd1;
               per = 32'd1;
            end
            1: begin
               dly = 32'hFFFF_FFFF;
               per = 32'hFFFF_FFFF;
            end
            2: dly = 32'd0;                            // dead: zero delay
            3: per = 32'd0;                            // dead: zero period
            4: begin                                   // dead: all lines shared
               dmap = 16'h0000;
               cmap = 16'hFFFF;
            end
            5: cmap = {cmap[15:4], dmap[3:0]};         // dead: back shares up's line
            6: stamp = 64'hFFFF_FFFF_FFFF_FF00;        // timestamp wraps mid-phase
            7: begin
               stamp = {$urandom, $urandom};
               if ($urandom_range(0, 1) == 0) begin
                  dmap = 16'($urandom);
                  cmap = 16'($urandom);
               end
            end
            default: ;
         endcase

         write_reg(CSR_DIRECTION_MAP, 32'(dmap));
         write_reg(CSR_COMMAND_MAP, 32'(cmap));
         write_reg(CSR_REPEAT_DELAY, dly);
         write_reg(CSR_REPEAT_PERIOD, per);

         // quiet handshakes in the last phase and now and then elsewhere
         idle_ok  = (phase != 9) && ($urandom_range(0, 3) != 0);
         count    = (phase >= 2 && phase <= 5) ? 15 : 55;
         held_now = '0;

         for (int n = 0; n < count; n++) begin
            // mostly press or release one mapped key so holds last for repeats
            r = $urandom_range(0, 99);
            if (r < 40) begin
               j = $urandom_range(0, 7);
               held_now[mapped[j]] = ~held_now[mapped[j]];
            end else if (r < 50) begin
               j = $urandom_range(0, 15);
               held_now[j] = ~held_now[j];
            end else if (r < 54) begin
               held_now = 16'($urandom);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
               stamp = stamp - 64'($urandom_range(1, 50));
            else if (r < 8 || dly > 32'd1000)
               stamp = stamp + {31'd0, 1'($urandom_range(0, 1)), $urandom};
            else
               stamp = stamp + 64'($urandom_range(0, 8));
            add_sample($urandom_range(0, 24) != 0, held_now, stamp);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && action_q.size() == 0)
         $display("button_action_mapper_autorepeat_core verification clean");
      else
         $display("button_action_mapper_autorepeat_core verification failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("button_action_mapper_autorepeat_core verification failed");
      $finish;
   end

endmodule
